>>> rtl/klifo_pkg.sv
`timescale 1ns / 1ps

package klifo_pkg;

    localparam int DEPTH   = 128;
    localparam int FILL_W  = $clog2(DEPTH + 1);
    localparam int KEY_W   = 32;
    localparam int PAY_W   = 32;
    localparam int OCC_W   = 8;
    localparam int STAT_W  = 3;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_PEEK   = 2'd2,
        OP_REMOVE = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_DUP      = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } rec_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic remove;
    } cell_ctrl_t;

endpackage

>>> rtl/keyed_lifo_stack.sv
`timescale 1ns / 1ps
// channel  | ports                                          | dir
// s_       | s_valid s_ready s_op s_key s_payload           | in
// m_       | m_valid m_ready m_status m_out_key             | out
//          | m_out_payload m_occupancy                      |
// one request per cycle while s_ready is high; its result is registered and shows in the cycle after acceptance
// top of stack sits in cell 0; every cell compares its key, and the match chain
// through the cells picks which cells shift toward the top on a removal
// s_ready stays high while the result register is empty or being taken
// reset clears the fill count and the result valid; cell contents stay undefined

module keyed_lifo_stack import klifo_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [1:0]              s_op,
    input  logic signed [KEY_W-1:0] s_key,
    input  logic [PAY_W-1:0]        s_payload,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [STAT_W-1:0]       m_status,
    output logic signed [KEY_W-1:0] m_out_key,
    output logic [PAY_W-1:0]        m_out_payload,
    output logic [OCC_W-1:0]        m_occupancy
);

    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic              m_valid_reg;
    status_t           status_reg;
    status_t           status_next;
    logic [KEY_W-1:0]  key_reg;
    logic [KEY_W-1:0]  key_next;
    logic [PAY_W-1:0]  pay_reg;
    logic [PAY_W-1:0]  pay_next;
    logic [OCC_W-1:0]  occ_reg;

    rec_t              cell_rec [DEPTH];
    logic [DEPTH:0]    hit;
    logic [DEPTH-1:0]  occupied;
    rec_t              in_rec;
    cell_ctrl_t        ctrl;
    logic              accept;
    logic              found;
    logic              empty;
    logic              full;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign in_rec  = '{key: s_key, payload: s_payload};
    assign hit[0]  = 1'b0;
    assign found   = hit[DEPTH];
    assign empty   = (fill_reg == '0);
    assign full    = (fill_reg == FILL_W'(DEPTH));

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        rec_t up_rec;
        rec_t down_rec;

        assign occupied[k] = (FILL_W'(k) < fill_reg);
        if (k == 0) begin : g_first
            assign up_rec = in_rec;
        end else begin : g_mid
            assign up_rec = cell_rec[k-1];
        end
        if (k == DEPTH - 1) begin : g_last
            assign down_rec = cell_rec[k];
        end else begin : g_inner
            assign down_rec = cell_rec[k+1];
        end

        klifo_cell u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .occupied   (occupied[k]),
            .search_key (s_key),
            .hit_in     (hit[k]),
            .up_rec     (up_rec),
            .down_rec   (down_rec),
            .rec        (cell_rec[k]),
            .hit_out    (hit[k+1])
        );
    end

    always_comb begin
        ctrl        = '0;
        status_next = ST_OK;
        key_next    = '0;
        pay_next    = '0;
        fill_next   = fill_reg;
        case (op_t'(s_op))
            OP_PUSH: begin
                if (full) begin
                    status_next = ST_FULL;
                end else if (found) begin
                    status_next = ST_DUP;
                end else begin
                    ctrl.push = accept;
                    fill_next = fill_reg + 1'b1;
                end
            end
            OP_POP, OP_PEEK: begin
                if (empty) begin
                    status_next = ST_EMPTY;
                end else begin
                    key_next = cell_rec[0].key;
                    pay_next = cell_rec[0].payload;
                    if (op_t'(s_op) == OP_POP) begin
                        ctrl.pop  = accept;
                        fill_next = fill_reg - 1'b1;
                    end
                end
            end
            OP_REMOVE: begin
                if (empty) begin
                    status_next = ST_EMPTY;
                end else if (!found) begin
                    status_next = ST_NOTFOUND;
                end else begin
                    ctrl.remove = accept;
                    fill_next   = fill_reg - 1'b1;
                end
            end
            default: begin
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                fill_reg    <= fill_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg <= status_next;
            key_reg    <= key_next;
            pay_reg    <= pay_next;
            occ_reg    <= OCC_W'(fill_next);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = status_reg;
    assign m_out_key     = key_reg;
    assign m_out_payload = pay_reg;
    assign m_occupancy   = occ_reg;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_W'(DEPTH))
        else $error("fill count above depth");

    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.push |=> fill_reg == $past(fill_reg) + 1'b1)
        else $error("push did not grow fill count");

    a_one_shift: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({ctrl.push, ctrl.pop, ctrl.remove}))
        else $error("conflicting shift controls");

    a_found_occupied: assert property (@(posedge aclk) disable iff (!aresetn)
        found |-> !empty)
        else $error("key match in empty stack");

    a_result_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_occupancy == OCC_W'(fill_reg))
        else $error("result occupancy differs from fill count");

endmodule

>>> rtl/klifo_cell.sv
`timescale 1ns / 1ps

module klifo_cell import klifo_pkg::*; (
    input  logic             aclk,
    input  cell_ctrl_t       ctrl,
    input  logic             occupied,
    input  logic [KEY_W-1:0] search_key,
    input  logic             hit_in,
    input  rec_t             up_rec,
    input  rec_t             down_rec,
    output rec_t             rec,
    output logic             hit_out
);

    rec_t rec_reg;
    rec_t rec_next;

    assign hit_out = hit_in | (occupied && (rec_reg.key == search_key));
    assign rec     = rec_reg;

    always_comb begin
        rec_next = rec_reg;
        if (ctrl.push) begin
            rec_next = up_rec;
        end else if (ctrl.pop) begin
            rec_next = down_rec;
        end else if (ctrl.remove && hit_out) begin
            rec_next = down_rec;
        end
    end

    always_ff @(posedge aclk) begin
        rec_reg <= rec_next;
    end

endmodule
